@@ hdl/stt_pkg.sv @@
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_MINUS,
        MODE_DIGITS,
        MODE_WORD,
        MODE_CR,
        MODE_DEAD
    } t_mode;

    typedef enum logic [2:0] {
        KIND_INT,
        KIND_INC,
        KIND_IOATA,
        KIND_NAME,
        KIND_NL,
        KIND_END,
        KIND_ERR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_ILLEGAL,
        ERR_MALFORMED
    } t_err;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // keyword spellings
    localparam logic [7:0] KW_INC   [3] = '{8'h69, 8'h6E, 8'h63};
    localparam logic [7:0] KW_IOATA [5] = '{8'h69, 8'h6F, 8'h61, 8'h74, 8'h61};

    localparam logic [67:0] MAG_CAP = 68'h0_8000_0000_0000_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_source;
    } t_in_word;

    typedef struct packed {
        t_kind              token_kind;
        t_err               error_code;
        logic [31:0]        start_offset;
        logic [31:0]        start_line;
        logic [31:0]        start_column;
        logic [15:0]        token_length;
        logic               preceded_by_space;
        logic signed [63:0] integer_value;
        logic               value_out_of_range;
        logic               run_last;
    } t_out_word;

    typedef struct packed {
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_lex_res;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // narrow keyword candidates by one more byte at position n
    function automatic logic [1:0] kw_step(logic [1:0] kw, logic n_small, logic [2:0] n,
                                           logic [7:0] c);
        logic [1:0] r;
        r = kw;
        if (!n_small || n > 3'd2 || KW_INC[n[1:0]] != c)
            r[0] = 1'b0;
        if (!n_small || n > 3'd4 || KW_IOATA[n] != c)
            r[1] = 1'b0;
        return r;
    endfunction

    function automatic t_out_word make_result(t_kind kind, t_err err, logic [31:0] off,
                                              logic [31:0] line, logic [31:0] col,
                                              logic [15:0] len, logic sp,
                                              logic [63:0] val, logic oor);
        t_out_word r;
        r.token_kind         = kind;
        r.error_code         = err;
        r.start_offset       = off;
        r.start_line         = line;
        r.start_column       = col;
        r.token_length       = len;
        r.preceded_by_space  = sp;
        r.integer_value      = val;
        r.value_out_of_range = oor;
        r.run_last           = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/stt_lexer.sv @@
module stt_lexer #(
    parameter int POSITION_WIDTH = 32,
    parameter int LENGTH_WIDTH   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  stt_pkg::t_in_word i_word,
    output stt_pkg::t_lex_res o_res
);

    localparam int PW = POSITION_WIDTH;
    localparam int LW = LENGTH_WIDTH;
    localparam logic [PW-1:0] POS_ONE = PW'(1);

    stt_pkg::t_mode r_mode, n_mode;
    logic [PW-1:0]  r_cur_off, n_cur_off, r_cur_line, n_cur_line, r_cur_col, n_cur_col;
    logic           r_space, n_space;
    logic [PW-1:0]  r_tok_off, n_tok_off, r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic           r_tok_sp, n_tok_sp;
    logic [LW-1:0]  r_cnt, n_cnt;
    logic [63:0]    r_acc, n_acc;
    logic           r_ovf, n_ovf;
    logic           r_neg, n_neg;
    logic [1:0]     r_kw, n_kw;

    function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] v);
        return (v == '1) ? v : v + POS_ONE;
    endfunction

    function automatic logic [31:0] pos32(logic [PW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    function automatic logic [15:0] len16(logic [LW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    always_comb begin : next_state
        stt_pkg::t_out_word slot [2];
        logic [1:0]  k;
        logic        do_idle;
        logic [7:0]  c;
        logic [3:0]  d;
        logic [67:0] prod;
        logic        prod_big;
        logic        oor;
        logic [63:0] val;
        stt_pkg::t_kind kind;

        n_mode     = r_mode;
        n_cur_off  = r_cur_off;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        n_space    = r_space;
        n_tok_off  = r_tok_off;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_tok_sp   = r_tok_sp;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_neg      = r_neg;
        n_kw       = r_kw;
        slot[0]    = '0;
        slot[1]    = '0;
        k          = 2'd0;
        do_idle    = 1'b0;
        oor        = 1'b0;
        val        = '0;
        kind       = stt_pkg::KIND_NAME;

        c        = i_word.text_byte;
        d        = 4'(c - stt_pkg::CH_ZERO);
        // acc * 10 + d
        prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 68'(d);
        prod_big = prod > stt_pkg::MAG_CAP;

        // pending integer or name, as it stands before this byte
        if (r_mode == stt_pkg::MODE_DIGITS) begin
            kind = stt_pkg::KIND_INT;
            oor  = r_ovf || (!r_neg && r_acc == stt_pkg::MAG_CAP[63:0]);
            if (!oor)
                val = r_neg ? (64'd0 - r_acc) : r_acc;
        end else if (r_kw[0] && r_cnt == LW'(3)) begin
            kind = stt_pkg::KIND_INC;
        end else if (r_kw[1] && r_cnt == LW'(5)) begin
            kind = stt_pkg::KIND_IOATA;
        end

        if (i_word.end_of_source) begin
            case (r_mode)
                stt_pkg::MODE_MINUS: begin
                    slot[0] = stt_pkg::make_result(stt_pkg::KIND_ERR, stt_pkg::ERR_MALFORMED,
                        pos32(r_tok_off), pos32(r_tok_line), pos32(r_tok_col), 16'd0, 1'b0,
                        64'd0, 1'b0);
                    k = 2'd1;
                end
                stt_pkg::MODE_CR: begin
                    slot[0] = stt_pkg::make_result(stt_pkg::KIND_ERR, stt_pkg::ERR_ILLEGAL,
                        pos32(r_tok_off), pos32(r_tok_line), pos32(r_tok_col), 16'd0, 1'b0,
                        64'd0, 1'b0);
                    k = 2'd1;
                end
                stt_pkg::MODE_DEAD: begin
                    k = 2'd0;
                end
                stt_pkg::MODE_DIGITS, stt_pkg::MODE_WORD: begin
                    // token then end; space flag is cleared by the token
                    slot[0] = stt_pkg::make_result(kind, stt_pkg::ERR_NONE, pos32(r_tok_off),
                        pos32(r_tok_line), pos32(r_tok_col), len16(r_cnt), r_tok_sp, val, oor);
                    slot[1] = stt_pkg::make_result(stt_pkg::KIND_END, stt_pkg::ERR_NONE,
                        pos32(r_cur_off), pos32(r_cur_line), pos32(r_cur_col), 16'd0, 1'b0,
                        64'd0, 1'b0);
                    k = 2'd2;
                end
                default: begin
                    slot[0] = stt_pkg::make_result(stt_pkg::KIND_END, stt_pkg::ERR_NONE,
                        pos32(r_cur_off), pos32(r_cur_line), pos32(r_cur_col), 16'd0, r_space,
                        64'd0, 1'b0);
                    k = 2'd1;
                end
            endcase
            n_mode     = stt_pkg::MODE_IDLE;
            n_cur_off  = '0;
            n_cur_line = POS_ONE;
            n_cur_col  = POS_ONE;
            n_space    = 1'b1;
            n_tok_off  = '0;
            n_tok_line = POS_ONE;
            n_tok_col  = POS_ONE;
            n_tok_sp   = 1'b0;
            n_cnt      = '0;
            n_acc      = '0;
            n_ovf      = 1'b0;
            n_neg      = 1'b0;
            n_kw       = 2'b11;
        end else begin
            case (r_mode)
                stt_pkg::MODE_DEAD: begin
                    k = 2'd0;
                end
                stt_pkg::MODE_CR: begin
                    if (c == stt_pkg::CH_LF) begin
                        slot[0] = stt_pkg::make_result(stt_pkg::KIND_NL, stt_pkg::ERR_NONE,
                            pos32(r_tok_off), pos32(r_tok_line), pos32(r_tok_col), 16'd2,
                            r_tok_sp, 64'd0, 1'b0);
                        k          = 2'd1;
                        n_cur_off  = sat_inc(r_cur_off);
                        n_cur_line = sat_inc(r_cur_line);
                        n_cur_col  = POS_ONE;
                        n_space    = 1'b1;
                        n_mode     = stt_pkg::MODE_IDLE;
                    end else begin
                        slot[0] = stt_pkg::make_result(stt_pkg::KIND_ERR, stt_pkg::ERR_ILLEGAL,
                            pos32(r_tok_off), pos32(r_tok_line), pos32(r_tok_col), 16'd0, 1'b0,
                            64'd0, 1'b0);
                        k      = 2'd1;
                        n_mode = stt_pkg::MODE_DEAD;
                    end
                end
                stt_pkg::MODE_MINUS, stt_pkg::MODE_DIGITS: begin
                    if (stt_pkg::is_digit(c)) begin
                        if (!r_ovf) begin
                            if (prod_big)
                                n_ovf = 1'b1;
                            else
                                n_acc = prod[63:0];
                        end
                        n_cnt     = (r_cnt == '1) ? r_cnt : r_cnt + LW'(1);
                        n_cur_off = sat_inc(r_cur_off);
                        n_cur_col = sat_inc(r_cur_col);
                        n_mode    = stt_pkg::MODE_DIGITS;
                    end else if (r_mode == stt_pkg::MODE_MINUS || stt_pkg::is_word(c)) begin
                        slot[0] = stt_pkg::make_result(stt_pkg::KIND_ERR, stt_pkg::ERR_MALFORMED,
                            pos32(r_tok_off), pos32(r_tok_line), pos32(r_tok_col), 16'd0, 1'b0,
                            64'd0, 1'b0);
                        k      = 2'd1;
                        n_mode = stt_pkg::MODE_DEAD;
                    end else begin
                        slot[0] = stt_pkg::make_result(kind, stt_pkg::ERR_NONE,
                            pos32(r_tok_off), pos32(r_tok_line), pos32(r_tok_col),
                            len16(r_cnt), r_tok_sp, val, oor);
                        k       = 2'd1;
                        n_space = 1'b0;
                        n_mode  = stt_pkg::MODE_IDLE;
                        do_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_WORD: begin
                    if (stt_pkg::is_word(c)) begin
                        n_kw      = stt_pkg::kw_step(r_kw, r_cnt < LW'(8), r_cnt[2:0], c);
                        n_cnt     = (r_cnt == '1) ? r_cnt : r_cnt + LW'(1);
                        n_cur_off = sat_inc(r_cur_off);
                        n_cur_col = sat_inc(r_cur_col);
                    end else begin
                        slot[0] = stt_pkg::make_result(kind, stt_pkg::ERR_NONE,
                            pos32(r_tok_off), pos32(r_tok_line), pos32(r_tok_col),
                            len16(r_cnt), r_tok_sp, val, oor);
                        k       = 2'd1;
                        n_space = 1'b0;
                        n_mode  = stt_pkg::MODE_IDLE;
                        do_idle = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            // byte seen between tokens (possibly right after a token closed)
            if (do_idle) begin
                if (c == stt_pkg::CH_CR || c == stt_pkg::CH_MINUS || stt_pkg::is_digit(c)
                        || stt_pkg::is_alpha(c)) begin
                    n_tok_off  = n_cur_off;
                    n_tok_line = n_cur_line;
                    n_tok_col  = n_cur_col;
                    n_tok_sp   = n_space;
                    n_cnt      = '0;
                    n_acc      = '0;
                    n_ovf      = 1'b0;
                    n_neg      = 1'b0;
                    n_kw       = 2'b11;
                end
                if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB) begin
                    n_cur_off = sat_inc(n_cur_off);
                    n_cur_col = sat_inc(n_cur_col);
                    n_space   = 1'b1;
                end else if (c == stt_pkg::CH_LF) begin
                    slot[k[0]] = stt_pkg::make_result(stt_pkg::KIND_NL, stt_pkg::ERR_NONE,
                        pos32(n_cur_off), pos32(n_cur_line), pos32(n_cur_col), 16'd1, n_space,
                        64'd0, 1'b0);
                    k          = k + 2'd1;
                    n_cur_off  = sat_inc(n_cur_off);
                    n_cur_line = sat_inc(n_cur_line);
                    n_cur_col  = POS_ONE;
                    n_space    = 1'b1;
                end else if (c == stt_pkg::CH_CR) begin
                    n_cur_off = sat_inc(n_cur_off);
                    n_cur_col = sat_inc(n_cur_col);
                    n_mode    = stt_pkg::MODE_CR;
                end else if (c == stt_pkg::CH_MINUS) begin
                    n_neg     = 1'b1;
                    n_cnt     = LW'(1);
                    n_cur_off = sat_inc(n_cur_off);
                    n_cur_col = sat_inc(n_cur_col);
                    n_mode    = stt_pkg::MODE_MINUS;
                end else if (stt_pkg::is_digit(c)) begin
                    n_acc     = 64'(d);
                    n_cnt     = LW'(1);
                    n_cur_off = sat_inc(n_cur_off);
                    n_cur_col = sat_inc(n_cur_col);
                    n_mode    = stt_pkg::MODE_DIGITS;
                end else if (stt_pkg::is_alpha(c)) begin
                    n_kw      = stt_pkg::kw_step(2'b11, 1'b1, 3'd0, c);
                    n_cnt     = LW'(1);
                    n_cur_off = sat_inc(n_cur_off);
                    n_cur_col = sat_inc(n_cur_col);
                    n_mode    = stt_pkg::MODE_WORD;
                end else begin
                    slot[k[0]] = stt_pkg::make_result(stt_pkg::KIND_ERR, stt_pkg::ERR_ILLEGAL,
                        pos32(n_cur_off), pos32(n_cur_line), pos32(n_cur_col), 16'd0, 1'b0,
                        64'd0, 1'b0);
                    k      = k + 2'd1;
                    n_mode = stt_pkg::MODE_DEAD;
                end
            end
        end

        if (k == 2'd1)
            slot[0].run_last = 1'b1;
        else if (k == 2'd2)
            slot[1].run_last = 1'b1;

        o_res.count  = k;
        o_res.first  = slot[0];
        o_res.second = slot[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= stt_pkg::MODE_IDLE;
            r_cur_off  <= '0;
            r_cur_line <= POS_ONE;
            r_cur_col  <= POS_ONE;
            r_space    <= 1'b1;
            r_tok_off  <= '0;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_tok_sp   <= 1'b0;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_neg      <= 1'b0;
            r_kw       <= 2'b11;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_cur_off  <= n_cur_off;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
            r_space    <= n_space;
            r_tok_off  <= n_tok_off;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_tok_sp   <= n_tok_sp;
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_neg      <= n_neg;
            r_kw       <= n_kw;
        end
    end

endmodule

@@ hdl/stt_result_queue.sv @@
module stt_result_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  stt_pkg::t_lex_res  i_res,
    output logic               o_full,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stt_pkg::t_out_word o_out_word
);

    localparam int AW = stt_pkg::QUEUE_AW;
    localparam int CW = AW + 1;

    stt_pkg::t_out_word r_mem [stt_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    push_n;
    logic          pop;

    assign push_n      = i_push ? i_res.count : 2'd0;
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_mem[r_rd];
    // room for the worst case of two results per word
    assign o_full      = (r_count > CW'(stt_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + AW'(push_n);
        n_rd    = pop ? r_rd + AW'(1) : r_rd;
        n_count = r_count + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0)
            r_mem[r_wr] <= i_res.first;
        if (push_n == 2'd2)
            r_mem[r_wr + AW'(1)] <= i_res.second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ hdl/source_text_tokenizer.sv @@
// Source text tokenizer.
// Input channel: one word per source byte (text_byte), or a closing word with
// end_of_source set that flushes any open token and yields the end token,
// unless a lone minus or CR is open or an error came before. Output channel:
// token and error results; run_last marks the last result caused by an input
// word (an input word causes zero, one or two).
// Throughput: one input word per cycle while o_in_stall is low; the scanner
// works out all results of a byte combinationally, including the
// multiply-by-ten step of the integer accumulator.
// The scanner feeds a four-entry result queue that offers results on
// o_out_valid. Input is stalled while more than two entries are held, so a
// stalled receiver backs up into o_in_stall and no result is dropped.
// Two results of one word drain at one per cycle while i_out_stall is low.
// Reset (i_rst_n low at a clock edge) empties the queue and puts the scanner
// between tokens at offset 0, line 1, column 1. After an end-of-source word
// the scanner returns to the same state, ready for the next source.
module source_text_tokenizer #(
    parameter int POSITION_WIDTH = 32,
    parameter int LENGTH_WIDTH   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stt_pkg::t_out_word o_out_word
);

    logic              accept;
    stt_pkg::t_lex_res lex_res;

    assign accept = i_in_valid && !o_in_stall;

    stt_lexer #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .LENGTH_WIDTH   (LENGTH_WIDTH)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .o_res    (lex_res)
    );

    stt_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_res       (lex_res),
        .o_full      (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_WORDS = 900;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    stt_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    stt_pkg::t_out_word out_word;

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int sent_words = 0;

    // scanner state mirrored from the block
    stt_pkg::t_mode sc_mode;
    logic [31:0] pos_off, pos_line, pos_col;
    logic        space_seen;
    logic [31:0] tk_off, tk_line, tk_col;
    logic        tk_space;
    logic [15:0] tk_len;
    logic [63:0] mag;
    logic        mag_ovf, neg;
    logic [1:0]  kw_alive;

    stt_pkg::t_out_word scan_out[$];
    stt_pkg::t_out_word expected_tokens[$];
    stt_pkg::t_out_word tok_want;
    logic [7:0] src_bytes[$];

    typedef struct {
        stt_pkg::t_in_word  w;
        bit                 typed;
        stt_pkg::t_out_word want;
    } t_dir_row;

    t_dir_row dir_rows[$];

    source_text_tokenizer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic add_byte(logic [7:0] b);
        src_bytes.insert(src_bytes.size(), b);
    endtask

    task automatic add_result(stt_pkg::t_out_word t);
        scan_out.insert(scan_out.size(), t);
    endtask

    task automatic add_expected(stt_pkg::t_out_word t);
        expected_tokens.insert(expected_tokens.size(), t);
    endtask

    task automatic add_row(t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic stt_pkg::t_out_word token_at(stt_pkg::t_kind kind, stt_pkg::t_err err,
                                                    logic [31:0] off, logic [31:0] line,
                                                    logic [31:0] col, logic [15:0] len,
                                                    logic sp, logic [63:0] val, logic oor);
        stt_pkg::t_out_word t;
        t = '0;
        t.token_kind = kind;
        t.error_code = err;
        t.start_offset = off;
        t.start_line = line;
        t.start_column = col;
        t.token_length = len;
        t.preceded_by_space = sp;
        t.integer_value = val;
        t.value_out_of_range = oor;
        return t;
    endfunction

    task automatic clear_scanner();
        sc_mode = stt_pkg::MODE_IDLE;
        pos_off = 32'd0;
        pos_line = 32'd1;
        pos_col = 32'd1;
        space_seen = 1'b1;
        tk_off = 32'd0;
        tk_line = 32'd1;
        tk_col = 32'd1;
        tk_space = 1'b0;
        tk_len = 16'd0;
        mag = 64'd0;
        mag_ovf = 1'b0;
        neg = 1'b0;
        kw_alive = 2'b11;
    endtask

    task automatic step_pos();
        pos_off = bump(pos_off);
        pos_col = bump(pos_col);
    endtask

    task automatic next_line();
        pos_off = bump(pos_off);
        pos_line = bump(pos_line);
        pos_col = 32'd1;
        space_seen = 1'b1;
    endtask

    task automatic count_len();
        if (tk_len != 16'hFFFF)
            tk_len = tk_len + 16'd1;
    endtask

    task automatic open_token();
        tk_off = pos_off;
        tk_line = pos_line;
        tk_col = pos_col;
        tk_space = space_seen;
        tk_len = 16'd0;
        mag = 64'd0;
        mag_ovf = 1'b0;
        neg = 1'b0;
        kw_alive = 2'b11;
    endtask

    task automatic take_digit(logic [7:0] c);
        logic [63:0] d;
        d = {60'd0, c[3:0]};
        if (!mag_ovf) begin
            if (mag > (64'h8000_0000_0000_0000 - d) / 64'd10)
                mag_ovf = 1'b1;
            else
                mag = mag * 64'd10 + d;
        end
    endtask

    task automatic narrow_keywords(logic [7:0] c);
        if (tk_len >= 16'd3 || stt_pkg::KW_INC[tk_len[1:0]] != c)
            kw_alive[0] = 1'b0;
        if (tk_len >= 16'd5 || stt_pkg::KW_IOATA[tk_len[2:0]] != c)
            kw_alive[1] = 1'b0;
    endtask

    task automatic fault(stt_pkg::t_err code, logic at_start);
        if (at_start)
            add_result(token_at(stt_pkg::KIND_ERR, code, tk_off, tk_line, tk_col,
                                16'd0, 1'b0, 64'd0, 1'b0));
        else
            add_result(token_at(stt_pkg::KIND_ERR, code, pos_off, pos_line, pos_col,
                                16'd0, 1'b0, 64'd0, 1'b0));
        sc_mode = stt_pkg::MODE_DEAD;
    endtask

    task automatic close_token();
        stt_pkg::t_kind kind;
        logic [63:0]    val;
        logic           oor;
        kind = stt_pkg::KIND_NAME;
        val = 64'd0;
        oor = 1'b0;
        if (sc_mode == stt_pkg::MODE_DIGITS) begin
            kind = stt_pkg::KIND_INT;
            oor = mag_ovf || (!neg && mag == 64'h8000_0000_0000_0000);
            if (!oor)
                val = neg ? 64'd0 - mag : mag;
        end else if (kw_alive[0] && tk_len == 16'd3) begin
            kind = stt_pkg::KIND_INC;
        end else if (kw_alive[1] && tk_len == 16'd5) begin
            kind = stt_pkg::KIND_IOATA;
        end
        add_result(token_at(kind, stt_pkg::ERR_NONE, tk_off, tk_line, tk_col, tk_len,
                            tk_space, val, oor));
        space_seen = 1'b0;
        sc_mode = stt_pkg::MODE_IDLE;
    endtask

    task automatic between_tokens(logic [7:0] c);
        if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB) begin
            step_pos();
            space_seen = 1'b1;
        end else if (c == stt_pkg::CH_LF) begin
            add_result(token_at(stt_pkg::KIND_NL, stt_pkg::ERR_NONE, pos_off, pos_line,
                                pos_col, 16'd1, space_seen, 64'd0, 1'b0));
            next_line();
        end else if (c == stt_pkg::CH_CR) begin
            open_token();
            step_pos();
            sc_mode = stt_pkg::MODE_CR;
        end else if (c == stt_pkg::CH_MINUS) begin
            open_token();
            neg = 1'b1;
            count_len();
            step_pos();
            sc_mode = stt_pkg::MODE_MINUS;
        end else if (is_num(c)) begin
            open_token();
            take_digit(c);
            count_len();
            step_pos();
            sc_mode = stt_pkg::MODE_DIGITS;
        end else if (is_letter(c)) begin
            open_token();
            narrow_keywords(c);
            count_len();
            step_pos();
            sc_mode = stt_pkg::MODE_WORD;
        end else begin
            fault(stt_pkg::ERR_ILLEGAL, 1'b0);
        end
    endtask

    // results caused by one accepted word, in order, left in scan_out
    task automatic scan_word(stt_pkg::t_in_word w);
        logic [7:0] c;
        c = w.text_byte;
        scan_out.delete();
        if (w.end_of_source) begin
            case (sc_mode)
                stt_pkg::MODE_MINUS: fault(stt_pkg::ERR_MALFORMED, 1'b1);
                stt_pkg::MODE_CR:    fault(stt_pkg::ERR_ILLEGAL, 1'b1);
                stt_pkg::MODE_DEAD:  ;
                default: begin
                    if (sc_mode == stt_pkg::MODE_DIGITS || sc_mode == stt_pkg::MODE_WORD)
                        close_token();
                    add_result(token_at(stt_pkg::KIND_END, stt_pkg::ERR_NONE, pos_off,
                                        pos_line, pos_col, 16'd0, space_seen, 64'd0, 1'b0));
                end
            endcase
            clear_scanner();
        end else begin
            case (sc_mode)
                stt_pkg::MODE_DEAD: ;
                stt_pkg::MODE_CR: begin
                    if (c == stt_pkg::CH_LF) begin
                        add_result(token_at(stt_pkg::KIND_NL, stt_pkg::ERR_NONE, tk_off,
                                            tk_line, tk_col, 16'd2, tk_space, 64'd0, 1'b0));
                        next_line();
                        sc_mode = stt_pkg::MODE_IDLE;
                    end else begin
                        fault(stt_pkg::ERR_ILLEGAL, 1'b1);
                    end
                end
                stt_pkg::MODE_MINUS: begin
                    if (is_num(c)) begin
                        take_digit(c);
                        count_len();
                        step_pos();
                        sc_mode = stt_pkg::MODE_DIGITS;
                    end else begin
                        fault(stt_pkg::ERR_MALFORMED, 1'b1);
                    end
                end
                stt_pkg::MODE_DIGITS: begin
                    if (is_num(c)) begin
                        take_digit(c);
                        count_len();
                        step_pos();
                    end else if (is_letter(c) || c == stt_pkg::CH_UNDER) begin
                        fault(stt_pkg::ERR_MALFORMED, 1'b1);
                    end else begin
                        close_token();
                        between_tokens(c);
                    end
                end
                stt_pkg::MODE_WORD: begin
                    if (is_letter(c) || is_num(c) || c == stt_pkg::CH_UNDER) begin
                        narrow_keywords(c);
                        count_len();
                        step_pos();
                    end else begin
                        close_token();
                        between_tokens(c);
                    end
                end
                default: between_tokens(c);
            endcase
        end
    endtask

    task automatic send_word(stt_pkg::t_in_word w, bit typed, stt_pkg::t_out_word want);
        stt_pkg::t_out_word t;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_words++;
        scan_word(w);
        if (typed) begin
            want.run_last = 1'b1;
            add_expected(want);
        end else begin
            foreach (scan_out[i]) begin
                t = scan_out[i];
                t.run_last = (i == scan_out.size() - 1);
                add_expected(t);
            end
        end
        @(negedge clk);
    endtask

    task automatic send_source();
        stt_pkg::t_in_word w;
        foreach (src_bytes[i]) begin
            w.text_byte = src_bytes[i];
            w.end_of_source = 1'b0;
            send_word(w, 1'b0, '0);
        end
        w.text_byte = 8'($urandom_range(0, 255));
        w.end_of_source = 1'b1;
        send_word(w, 1'b0, '0);
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52)
            return rand_letter();
        else if (r < 62)
            return stt_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        return stt_pkg::CH_UNDER;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_digits(int n);
        repeat (n)
            add_byte(stt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_token();
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 19: begin
                if ($urandom_range(0, 1))
                    add_byte(stt_pkg::CH_MINUS);
                add_digits($urandom_range(0, 4) == 0 ? $urandom_range(15, 25)
                                                     : $urandom_range(1, 6));
            end
            6: case ($urandom_range(0, 7))
                0: add_text("9223372036854775807");
                1: add_text("-9223372036854775808");
                2: add_text("9223372036854775808");
                3: add_text("-9223372036854775809");
                4: add_text("18446744073709551616");
                5: add_text("0");
                6: add_text("-0");
                default: add_text("000123");
            endcase
            7: add_text("inc");
            8: add_text("ioata");
            9: case ($urandom_range(0, 7))
                0: add_text("in");
                1: add_text("inca");
                2: add_text("ioat");
                3: add_text("ioatas");
                4: add_text("Inc");
                5: add_text("i");
                6: add_text("inc_");
                default: add_text("ioata9");
            endcase
            10, 11, 12, 13, 18: begin
                add_byte(rand_letter());
                repeat ($urandom_range(0, 8))
                    add_byte(rand_name_char());
            end
            14: add_byte(stt_pkg::CH_LF);
            15: add_text("\r\n");
            16: add_byte(8'($urandom_range(0, 255)));
            default: case ($urandom_range(0, 2))
                0: begin
                    b = 8'($urandom_range(0, 255));
                    add_byte(stt_pkg::CH_CR);
                    add_byte(b == stt_pkg::CH_LF ? 8'h78 : b);
                end
                1: begin
                    b = 8'($urandom_range(0, 255));
                    add_byte(stt_pkg::CH_MINUS);
                    add_byte(is_num(b) ? stt_pkg::CH_SPACE : b);
                end
                default: begin
                    add_digits($urandom_range(1, 3));
                    add_byte($urandom_range(0, 3) == 0 ? stt_pkg::CH_UNDER : rand_letter());
                end
            endcase
        endcase
    endtask

    task automatic build_source();
        src_bytes.delete();
        if ($urandom_range(0, 3) == 0)
            add_byte($urandom_range(0, 1) ? stt_pkg::CH_SPACE : stt_pkg::CH_TAB);
        repeat ($urandom_range(1, 12)) begin
            add_token();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 8:
                    repeat ($urandom_range(1, 3))
                        add_byte($urandom_range(0, 2) == 0 ? stt_pkg::CH_TAB
                                                           : stt_pkg::CH_SPACE);
                5, 6: add_byte(stt_pkg::CH_LF);
                7: add_text("\r\n");
                default: ;
            endcase
        end
        // open CR or minus left at the end of the source
        case ($urandom_range(0, 9))
            0: add_byte(stt_pkg::CH_CR);
            1: add_byte(stt_pkg::CH_MINUS);
            default: ;
        endcase
    endtask

    function automatic t_dir_row row_plain(logic [7:0] b, logic eos);
        t_dir_row r;
        r.w.text_byte = b;
        r.w.end_of_source = eos;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_dir_row row_checked(logic [7:0] b, logic eos,
                                             stt_pkg::t_out_word want);
        t_dir_row r;
        r = row_plain(b, eos);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected result: kind %0d offset %0d", out_word.token_kind,
                       out_word.start_offset);
                mismatches++;
            end else begin
                tok_want = expected_tokens.pop_front();
                if (out_word.token_kind !== tok_want.token_kind) begin
                    $error("token_kind: expected %0d, got %0d", tok_want.token_kind,
                           out_word.token_kind);
                    mismatches++;
                end
                if (out_word.error_code !== tok_want.error_code) begin
                    $error("error_code: expected %0d, got %0d", tok_want.error_code,
                           out_word.error_code);
                    mismatches++;
                end
                if (out_word.start_offset !== tok_want.start_offset) begin
                    $error("start_offset: expected %0d, got %0d", tok_want.start_offset,
                           out_word.start_offset);
                    mismatches++;
                end
                if (out_word.start_line !== tok_want.start_line) begin
                    $error("start_line: expected %0d, got %0d", tok_want.start_line,
                           out_word.start_line);
                    mismatches++;
                end
                if (out_word.start_column !== tok_want.start_column) begin
                    $error("start_column: expected %0d, got %0d", tok_want.start_column,
                           out_word.start_column);
                    mismatches++;
                end
                if (out_word.token_length !== tok_want.token_length) begin
                    $error("token_length: expected %0d, got %0d", tok_want.token_length,
                           out_word.token_length);
                    mismatches++;
                end
                if (out_word.preceded_by_space !== tok_want.preceded_by_space) begin
                    $error("preceded_by_space: expected %0d, got %0d",
                           tok_want.preceded_by_space, out_word.preceded_by_space);
                    mismatches++;
                end
                if (out_word.integer_value !== tok_want.integer_value) begin
                    $error("integer_value: expected %0d, got %0d", tok_want.integer_value,
                           out_word.integer_value);
                    mismatches++;
                end
                if (out_word.value_out_of_range !== tok_want.value_out_of_range) begin
                    $error("value_out_of_range: expected %0d, got %0d",
                           tok_want.value_out_of_range, out_word.value_out_of_range);
                    mismatches++;
                end
                if (out_word.run_last !== tok_want.run_last) begin
                    $error("run_last: expected %0d, got %0d", tok_want.run_last,
                           out_word.run_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int src_count;
        clear_scanner();

        // keyword, negative integer ended by CR LF, name then LF, bad byte, ignored tail
        add_row(row_plain("i", 1'b0));
        add_row(row_plain("o", 1'b0));
        add_row(row_plain("a", 1'b0));
        add_row(row_plain("t", 1'b0));
        add_row(row_plain("a", 1'b0));
        add_row(row_checked(stt_pkg::CH_TAB, 1'b0, token_at(stt_pkg::KIND_IOATA,
            stt_pkg::ERR_NONE, 32'd0, 32'd1, 32'd1, 16'd5, 1'b1, 64'd0, 1'b0)));
        add_row(row_plain(stt_pkg::CH_MINUS, 1'b0));
        add_row(row_plain("7", 1'b0));
        add_row(row_checked(stt_pkg::CH_CR, 1'b0, token_at(stt_pkg::KIND_INT,
            stt_pkg::ERR_NONE, 32'd6, 32'd1, 32'd7, 16'd2, 1'b1, -64'sd7, 1'b0)));
        add_row(row_checked(stt_pkg::CH_LF, 1'b0, token_at(stt_pkg::KIND_NL,
            stt_pkg::ERR_NONE, 32'd8, 32'd1, 32'd9, 16'd2, 1'b0, 64'd0, 1'b0)));
        add_row(row_plain("x", 1'b0));
        add_row(row_plain(stt_pkg::CH_UNDER, 1'b0));
        add_row(row_plain("9", 1'b0));
        add_row(row_plain(stt_pkg::CH_LF, 1'b0));
        add_row(row_checked(8'hFF, 1'b0, token_at(stt_pkg::KIND_ERR, stt_pkg::ERR_ILLEGAL,
            32'd14, 32'd3, 32'd1, 16'd0, 1'b0, 64'd0, 1'b0)));
        add_row(row_plain(8'h00, 1'b0));
        add_row(row_plain(8'h00, 1'b1));
        // minus followed by a space
        add_row(row_plain(stt_pkg::CH_MINUS, 1'b0));
        add_row(row_checked(stt_pkg::CH_SPACE, 1'b0, token_at(stt_pkg::KIND_ERR,
            stt_pkg::ERR_MALFORMED, 32'd0, 32'd1, 32'd1, 16'd0, 1'b0, 64'd0, 1'b0)));
        add_row(row_plain(8'hFF, 1'b1));
        // digit glued to underscore
        add_row(row_plain("3", 1'b0));
        add_row(row_checked(stt_pkg::CH_UNDER, 1'b0, token_at(stt_pkg::KIND_ERR,
            stt_pkg::ERR_MALFORMED, 32'd0, 32'd1, 32'd1, 16'd0, 1'b0, 64'd0, 1'b0)));
        add_row(row_plain(8'h00, 1'b1));
        // CR left open at end of source
        add_row(row_plain(stt_pkg::CH_CR, 1'b0));
        add_row(row_checked(8'h00, 1'b1, token_at(stt_pkg::KIND_ERR, stt_pkg::ERR_ILLEGAL,
            32'd0, 32'd1, 32'd1, 16'd0, 1'b0, 64'd0, 1'b0)));
        // integer flushed by end of source, then the end token
        add_row(row_plain("8", 1'b0));
        add_row(row_plain(8'h00, 1'b1));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

        sent_words = 0;
        src_count = 0;
        while (sent_words < RANDOM_WORDS) begin
            case ((src_count / 6) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            build_source();
            send_source();
            src_count++;
        end

        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/stt_pkg.sv
hdl/stt_lexer.sv
hdl/stt_result_queue.sv
hdl/source_text_tokenizer.sv
verif/testbench.sv
